### sv/frp_pkg.sv
// Shared types, character codes and helper functions for the FASTA/FASTQ record parser.
// No dependencies; every other file of the block imports this package.
package frp_pkg;

   localparam int POSITION_BITS = 32;
   localparam int LEN_BITS      = 32;

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [LEN_BITS-1:0]      len_type;

   localparam len_type LEN_NONE = '1;

   localparam logic [7:0] CHAR_HDR_FASTA = 8'h3E;
   localparam logic [7:0] CHAR_HDR_FASTQ = 8'h40;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_VT        = 8'h0B;
   localparam logic [7:0] CHAR_FF        = 8'h0C;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_SEQ  = 2'd1,
      PH_QUAL = 2'd2
   } phase_type;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef struct packed {
      logic [31:0] start_offset;
      logic [31:0] end_offset;
      logic [31:0] id_len;
      logic [31:0] comment_length;
      logic [31:0] seq_len;
      logic [31:0] qual_len;
      logic        is_fastq;
      logic        fault;
      logic        last_of_run;
   } rsp_type;

   // Descriptors produced by one item: count is 0, 1 or 2, first is sent first
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } emit_type;

   function automatic pos_type pos_inc(input pos_type p);
      return (p == {POSITION_BITS{1'b1}}) ? p : p + pos_type'(1);
   endfunction

   function automatic len_type len_add(input len_type a, input len_type b);
      logic [LEN_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_BITS] ? LEN_NONE : s[LEN_BITS-1:0];
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) ||
             (b == CHAR_VT) || (b == CHAR_FF);
   endfunction

   // Clamp a stream offset to the 32-bit output range
   function automatic logic [31:0] pos_to_out(input pos_type p);
      logic [63:0] w;
      w = 64'(p);
      return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   function automatic rsp_type make_rsp(input pos_type start, input pos_type stop,
                                        input len_type id, input len_type cmt,
                                        input len_type seq, input len_type qual,
                                        input logic fault);
      rsp_type r;
      r.start_offset   = pos_to_out(start);
      r.end_offset     = pos_to_out(stop);
      r.id_len         = 32'(id);
      r.comment_length = 32'(cmt);
      r.seq_len        = 32'(seq);
      r.qual_len       = 32'(qual);
      r.is_fastq       = !fault && (qual != '0);
      r.fault          = fault;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

endpackage

### sv/frp_parse_core.sv
// Parser state and the per-item step: line tracking, header split, record totals.
// Depends on frp_pkg.
module frp_parse_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              kind,
   input  logic [7:0]        data_byte,
   output frp_pkg::emit_type emit
);
   import frp_pkg::*;

   phase_type   phase_ff, phase_in;
   pos_type     pos_ff, pos_in;
   pos_type     line_start_ff, line_start_in;
   len_type     raw_len_ff, raw_len_in;
   logic [7:0]  first_byte_ff, first_byte_in;
   logic        prev_cr_ff, prev_cr_in;
   logic        cr2_ff, cr2_in;
   len_type     space_off_ff, space_off_in;
   len_type     cstart_off_ff, cstart_off_in;
   pos_type     rec_start_ff, rec_start_in;
   len_type     id_len_ff, id_len_in;
   len_type     cmt_len_ff, cmt_len_in;
   len_type     seq_tot_ff, seq_tot_in;
   len_type     qual_tot_ff, qual_tot_in;

   len_type     eff_len;
   logic [7:0]  lead;
   logic        is_hdr;
   logic        do_close;
   len_type     id_end;
   len_type     cmt_start;
   len_type     cmt_len;
   len_type     qual_sum;
   len_type     seq_sum;
   logic        close_emit;
   logic        end_emit;
   rsp_type     close_rsp;
   rsp_type     end_rsp;
   rsp_type     first_rsp;
   pos_type     stream_end;
   pos_type     next_pos;

   always_comb begin
      // trimmed line length and its header split
      eff_len = raw_len_ff;
      if (raw_len_ff != '0 && prev_cr_ff && raw_len_ff != LEN_NONE) begin
         eff_len = raw_len_ff - len_type'(1);
      end
      lead      = (eff_len != '0) ? first_byte_ff : 8'h00;
      is_hdr    = (lead == CHAR_HDR_FASTA) || (lead == CHAR_HDR_FASTQ);
      do_close  = ((kind == KIND_DATA) && (data_byte == CHAR_LF)) ||
                  ((kind == KIND_END) && (raw_len_ff != '0));
      id_end    = (space_off_ff < eff_len) ? space_off_ff : eff_len;
      cmt_start = (cstart_off_ff < eff_len) ? cstart_off_ff : eff_len;
      cmt_len   = eff_len - cmt_start;
      if (cmt_len != '0 && prev_cr_ff && cr2_ff) begin
         cmt_len = cmt_len - len_type'(1);
      end
      qual_sum = len_add(qual_tot_ff, eff_len);
      seq_sum  = len_add(seq_tot_ff, eff_len);
      next_pos = pos_inc(pos_ff);

      // hold by default
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      line_start_in = line_start_ff;
      raw_len_in    = raw_len_ff;
      first_byte_in = first_byte_ff;
      prev_cr_in    = prev_cr_ff;
      cr2_in        = cr2_ff;
      space_off_in  = space_off_ff;
      cstart_off_in = cstart_off_ff;
      rec_start_in  = rec_start_ff;
      id_len_in     = id_len_ff;
      cmt_len_in    = cmt_len_ff;
      seq_tot_in    = seq_tot_ff;
      qual_tot_in   = qual_tot_ff;
      close_emit    = 1'b0;
      close_rsp     = '0;
      end_emit      = 1'b0;
      end_rsp       = '0;
      stream_end    = pos_ff;

      // close the current line
      if (do_close) begin
         if (phase_ff == PH_SEQ && is_hdr) begin
            close_emit = 1'b1;
            close_rsp  = make_rsp(rec_start_ff, line_start_ff, id_len_ff, cmt_len_ff,
                                  seq_tot_ff, '0, 1'b0);
            phase_in   = PH_WAIT;
         end
         case (phase_in)
            PH_WAIT: begin
               if (is_hdr) begin
                  rec_start_in = line_start_ff;
                  id_len_in    = (id_end != '0) ? id_end - len_type'(1) : '0;
                  cmt_len_in   = cmt_len;
                  seq_tot_in   = '0;
                  qual_tot_in  = '0;
                  phase_in     = PH_SEQ;
               end
            end
            PH_SEQ: begin
               if (lead == CHAR_PLUS) begin
                  phase_in = PH_QUAL;
               end else begin
                  seq_tot_in = seq_sum;
               end
            end
            PH_QUAL: begin
               qual_tot_in = qual_sum;
               if (qual_sum >= seq_tot_ff) begin
                  close_emit = 1'b1;
                  close_rsp  = make_rsp(rec_start_ff, next_pos, id_len_ff, cmt_len_ff,
                                        seq_tot_ff, qual_sum, qual_sum != seq_tot_ff);
                  phase_in   = PH_WAIT;
               end
            end
            default: ;
         endcase
      end

      if (kind == KIND_END) begin
         // flush the open record, then restart the stream at the same offset
         if (raw_len_ff != '0) begin
            stream_end = next_pos;
         end
         if (phase_in == PH_SEQ) begin
            end_emit = 1'b1;
            end_rsp  = make_rsp(rec_start_in, stream_end, id_len_in, cmt_len_in,
                                seq_tot_in, '0, 1'b0);
         end else if (phase_in == PH_QUAL) begin
            end_emit = 1'b1;
            end_rsp  = make_rsp(rec_start_in, stream_end, id_len_in, cmt_len_in,
                                seq_tot_in, qual_tot_in, qual_tot_in != seq_tot_in);
         end
         phase_in      = PH_WAIT;
         line_start_in = pos_ff;
         raw_len_in    = '0;
         first_byte_in = 8'h00;
         prev_cr_in    = 1'b0;
         cr2_in        = 1'b0;
         space_off_in  = LEN_NONE;
         cstart_off_in = LEN_NONE;
      end else if (data_byte == CHAR_LF) begin
         pos_in        = next_pos;
         line_start_in = next_pos;
         raw_len_in    = '0;
         first_byte_in = 8'h00;
         prev_cr_in    = 1'b0;
         cr2_in        = 1'b0;
         space_off_in  = LEN_NONE;
         cstart_off_in = LEN_NONE;
      end else begin
         // plain byte: track first byte, whitespace marks and CR history
         if (raw_len_ff == '0) begin
            first_byte_in = data_byte;
         end else if (space_off_ff == LEN_NONE) begin
            if (is_space(data_byte)) begin
               space_off_in = raw_len_ff;
            end
         end else if (cstart_off_ff == LEN_NONE && !is_space(data_byte)) begin
            cstart_off_in = raw_len_ff;
         end
         cr2_in     = prev_cr_ff;
         prev_cr_in = (data_byte == CHAR_CR);
         raw_len_in = len_add(raw_len_ff, len_type'(1));
         pos_in     = next_pos;
      end
   end

   always_comb begin
      first_rsp             = close_emit ? close_rsp : end_rsp;
      first_rsp.last_of_run = !(close_emit && end_emit);
      emit.count            = {1'b0, close_emit} + {1'b0, end_emit};
      emit.first            = first_rsp;
      emit.second           = end_rsp;
      emit.second.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         pos_ff        <= '0;
         line_start_ff <= '0;
         raw_len_ff    <= '0;
         first_byte_ff <= 8'h00;
         prev_cr_ff    <= 1'b0;
         cr2_ff        <= 1'b0;
         space_off_ff  <= LEN_NONE;
         cstart_off_ff <= LEN_NONE;
         rec_start_ff  <= '0;
         id_len_ff     <= '0;
         cmt_len_ff    <= '0;
         seq_tot_ff    <= '0;
         qual_tot_ff   <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         line_start_ff <= line_start_in;
         raw_len_ff    <= raw_len_in;
         first_byte_ff <= first_byte_in;
         prev_cr_ff    <= prev_cr_in;
         cr2_ff        <= cr2_in;
         space_off_ff  <= space_off_in;
         cstart_off_ff <= cstart_off_in;
         rec_start_ff  <= rec_start_in;
         id_len_ff     <= id_len_in;
         cmt_len_ff    <= cmt_len_in;
         seq_tot_ff    <= seq_tot_in;
         qual_tot_ff   <= qual_tot_in;
      end
   end

`ifndef NO_ASSERTIONS
   // while collecting quality the total stays short of the sequence length
   a_qual_below_seq: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_QUAL |-> (qual_tot_ff < seq_tot_ff) || (qual_tot_ff == '0))
      else $error("quality total reached sequence length without closing record");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && kind == KIND_END |=> phase_ff == PH_WAIT && raw_len_ff == '0)
      else $error("end item left a record or line open");

   a_two_only_at_end: assert property (@(posedge clock) disable iff (reset)
      step && emit.count == 2'd2 |-> kind == KIND_END)
      else $error("two descriptors from a data byte");

   a_empty_line_no_cr: assert property (@(posedge clock) disable iff (reset)
      raw_len_ff == '0 |-> !prev_cr_ff && !cr2_ff)
      else $error("CR history set on an empty line");
`endif

endmodule

### sv/frp_rsp_queue.sv
// Two-entry result queue: takes up to two descriptors per step, sends one per cycle while rsp_ready is high.
// Depends on frp_pkg.
module frp_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_req,
   input  frp_pkg::emit_type emit,
   output logic              take,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output frp_pkg::rsp_type  head
);
   import frp_pkg::*;

   logic [1:0] count_ff, count_in;
   rsp_type    slot_a_ff, slot_a_in;
   rsp_type    slot_b_ff, slot_b_in;
   logic       pop;
   logic [1:0] kept;
   logic [2:0] fill;
   rsp_type    rem0;

   always_comb begin
      rsp_valid = (count_ff != 2'd0);
      head      = slot_a_ff;
      pop       = rsp_valid && rsp_ready;
      kept      = count_ff - {1'b0, pop};
      fill      = {1'b0, kept} + {1'b0, emit.count};
      // take the item only if all its descriptors fit after this cycle's pop
      take      = push_req && (fill <= 3'd2);
      rem0      = pop ? slot_b_ff : slot_a_ff;
      slot_a_in = (kept != 2'd0) ? rem0 : emit.first;
      if (kept == 2'd2) begin
         slot_b_in = slot_b_ff;
      end else if (kept == 2'd1) begin
         slot_b_in = emit.first;
      end else begin
         slot_b_in = emit.second;
      end
      count_in = take ? fill[1:0] : kept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_a_ff <= slot_a_in;
      slot_b_ff <= slot_b_in;
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue over capacity");

   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      take |-> push_req)
      else $error("queue took a step without an item");
`endif

endmodule

### sv/fastq_fasta_record_parser.sv
// Top level of the FASTA/FASTQ record parser: input register, parse core, result queue.
// Depends on frp_pkg, frp_parse_core and frp_rsp_queue.
//
// Usage:
//   req channel: one item per handshake, req_kind = 0 carries a stream byte in
//   req_data_byte, req_kind = 1 marks end of input and closes an open line and
//   record. Each item yields zero, one or two record descriptors.
//   rsp channel: one descriptor per handshake, with offsets, identifier,
//   comment, sequence and quality lengths, format flag and fault flag;
//   rsp_last_of_run marks the last descriptor caused by one item.
//   Path: an accepted item waits in the input register, is parsed when its
//   descriptors fit in the queue, and its first descriptor is offered on rsp.
//   Throughput: one item per cycle while the queue has room for its
//   descriptors. The single parse step between the input register and the
//   two-entry result queue sets this; an end item closing two records queues both.
//   Reset: synchronous, clears the parse state to "waiting for header" at
//   offset zero and empties both the input register and the queue.
//   Stall: while rsp_ready is low the queue keeps its descriptors; items that
//   produce no descriptor still pass, and the input register holds the next
//   item until its descriptors fit, which drops req_ready.
module fastq_fasta_record_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_start_offset,
   output logic [31:0] rsp_end_offset,
   output logic [31:0] rsp_id_len,
   output logic [31:0] rsp_comment_len,
   output logic [31:0] rsp_seq_len,
   output logic [31:0] rsp_qual_len,
   output logic        rsp_is_fastq,
   output logic        rsp_fault,
   output logic        rsp_last_of_run
);
   import frp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic [7:0] in_byte_ff;
   logic       take;
   emit_type   emit;
   rsp_type    head;

   // the input register frees up whenever its item moves into the parser
   assign req_ready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the payload until a new item is accepted
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_data_byte;
      end
   end

   // advance the parse state only when the item's descriptors are taken
   frp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (take),
      .kind      (in_kind_ff),
      .data_byte (in_byte_ff),
      .emit      (emit)
   );

   frp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_req  (in_valid_ff),
      .emit      (emit),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_start_offset = head.start_offset;
   assign rsp_end_offset   = head.end_offset;
   assign rsp_id_len       = head.id_len;
   assign rsp_comment_len  = head.comment_length;
   assign rsp_seq_len      = head.seq_len;
   assign rsp_qual_len     = head.qual_len;
   assign rsp_is_fastq     = head.is_fastq;
   assign rsp_fault        = head.fault;
   assign rsp_last_of_run  = head.last_of_run;

endmodule
